// ----- rtl/sxst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxst_pkg
// Shared types, codes and helpers of the SNR crossing steer trigger.
// ----------------------------------------------------------------------------
package sxst_pkg;

  localparam int unsigned SnrW     = 8;
  localparam int unsigned TrafficW = 48;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [2:0] {
    EV_SNR        = 3'd0,
    EV_TRAFFIC    = 3'd1,
    EV_CONNECT    = 3'd2,
    EV_DISCONNECT = 3'd3,
    EV_TICK       = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    WM_HIGH       = 2'd0,
    WM_LOW        = 2'd1,
    WM_BOTTOM_LOW = 2'd2
  } watermark_e;

  typedef enum logic [1:0] {
    CROSS_NONE = 2'd0,
    CROSS_UP   = 2'd1,
    CROSS_DOWN = 2'd2
  } crossing_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SNR_THRESHOLD  = 3'd0,
    REG_WATERMARK_MODE = 3'd1,
    REG_IDLE_LIMIT_EN  = 3'd2,
    REG_IDLE_BYTES_LIM = 3'd3,
    REG_ENFORCE_TICKS  = 3'd4
  } cfg_reg_e;

  localparam logic [TicksW-1:0] EnforceTicksReset = 16'd5;

  typedef struct packed {
    logic [SnrW-1:0]     snr_threshold;
    logic [1:0]          watermark_mode;
    logic                idle_limit_enable;
    logic [TrafficW-1:0] idle_bytes_limit;
    logic [TicksW-1:0]   enforce_ticks;
  } cfg_t;

  typedef struct packed {
    logic [SnrW-1:0]     older_snr;
    logic [SnrW-1:0]     newer_snr;
    logic [1:0]          snr_fill;
    logic [TrafficW-1:0] last_traffic;
    logic                traffic_seen;
    logic                pending_flag;
    logic                idle_flag;
    logic                cap_beacon;
    logic                cap_transition;
    logic                station_present;
    logic [TicksW-1:0]   ticks_left;
  } state_t;

  typedef struct packed {
    logic      enforce_start;
    logic      enforce_end;
    logic      enforce_active;
    crossing_e crossing;
    logic      pending;
    logic      traffic_idle;
  } result_t;

  // Crossing seen between the two held samples; none until two are held.
  function automatic crossing_e snr_crossing(input logic [1:0]      fill,
                                             input logic [SnrW-1:0] older,
                                             input logic [SnrW-1:0] newer,
                                             input logic [SnrW-1:0] thr);
    logic old_hi;
    logic new_hi;
    crossing_e x;
    old_hi = (older >= thr);
    new_hi = (newer >= thr);
    x = CROSS_NONE;
    if (fill == 2'd2) begin
      if (!old_hi && new_hi) begin
        x = CROSS_UP;
      end else if (old_hi && !new_hi) begin
        x = CROSS_DOWN;
      end
    end
    return x;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sxst_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxst_core
// Next-state and result logic for one event item.
// ----------------------------------------------------------------------------
module sxst_core (
  input  sxst_pkg::cfg_t                    cfg_i,
  input  sxst_pkg::state_t                  state_i,
  input  logic [2:0]                        mode_i,
  input  logic [sxst_pkg::SnrW-1:0]         snr_db_i,
  input  logic [sxst_pkg::TrafficW-1:0]     traffic_bytes_i,
  input  logic                              has_beacon_report_i,
  input  logic                              has_bss_transition_i,
  output sxst_pkg::state_t                  state_o,
  output sxst_pkg::result_t                 result_o
);
  import sxst_pkg::*;

  state_t            n;
  logic              do_eval;
  logic              start;
  logic              stop;
  logic              caps_ok;
  logic              idle;
  crossing_e         x;
  logic [TicksW-1:0] ticks_dec;

  assign ticks_dec = state_i.ticks_left - TicksW'(1);

  always_comb begin
    n       = state_i;
    do_eval = 1'b0;
    start   = 1'b0;
    stop    = 1'b0;
    caps_ok = 1'b0;
    idle    = 1'b0;
    x       = CROSS_NONE;

    case (event_e'(mode_i))
      EV_SNR: begin
        n.older_snr = state_i.newer_snr;
        n.newer_snr = snr_db_i;
        if (state_i.snr_fill != 2'd2) begin
          n.snr_fill = state_i.snr_fill + 2'd1;
        end
        do_eval = 1'b1;
      end
      EV_TRAFFIC: begin
        n.last_traffic = traffic_bytes_i;
        n.traffic_seen = 1'b1;
        do_eval        = 1'b1;
      end
      EV_CONNECT: begin
        n.station_present = 1'b1;
        n.cap_beacon      = state_i.cap_beacon | has_beacon_report_i;
        n.cap_transition  = state_i.cap_transition | has_bss_transition_i;
      end
      EV_DISCONNECT: begin
        stop = (state_i.ticks_left != '0);
        n    = '0;
      end
      EV_TICK: begin
        if (state_i.ticks_left != '0) begin
          if (ticks_dec == '0) begin
            // period over: drop history, keep the station
            n                 = '0;
            n.station_present = state_i.station_present;
            stop              = 1'b1;
          end else begin
            n.ticks_left = ticks_dec;
          end
        end
      end
      default: begin
      end
    endcase

    case (watermark_e'(cfg_i.watermark_mode))
      WM_HIGH:       caps_ok = 1'b1;
      WM_LOW:        caps_ok = 1'b1;
      WM_BOTTOM_LOW: caps_ok = !n.cap_beacon && !n.cap_transition;
      default:       caps_ok = 1'b0;
    endcase

    if (do_eval && n.station_present && (n.ticks_left == '0) && caps_ok) begin
      x = snr_crossing(n.snr_fill, n.older_snr, n.newer_snr, cfg_i.snr_threshold);
      if (x == CROSS_UP) begin
        n.pending_flag = (cfg_i.watermark_mode == WM_HIGH);
      end else if (x == CROSS_DOWN) begin
        n.pending_flag = (cfg_i.watermark_mode != WM_HIGH);
      end

      if (cfg_i.watermark_mode == WM_BOTTOM_LOW || !cfg_i.idle_limit_enable) begin
        idle = 1'b1;
      end else if (!n.traffic_seen) begin
        idle = 1'b0;
      end else begin
        idle = (n.last_traffic < cfg_i.idle_bytes_limit);
      end
      n.idle_flag = idle;

      if ((cfg_i.watermark_mode == WM_BOTTOM_LOW || idle) && n.pending_flag) begin
        n.pending_flag = 1'b0;
        n.ticks_left   = (cfg_i.enforce_ticks != '0) ? cfg_i.enforce_ticks : TicksW'(1);
        start          = 1'b1;
      end
    end
  end

  assign state_o                 = n;
  assign result_o.enforce_start  = start;
  assign result_o.enforce_end    = stop;
  assign result_o.enforce_active = (n.ticks_left != '0);
  assign result_o.crossing       = snr_crossing(n.snr_fill, n.older_snr, n.newer_snr,
                                                cfg_i.snr_threshold);
  assign result_o.pending        = n.pending_flag;
  assign result_o.traffic_idle   = n.idle_flag;

endmodule
`default_nettype wire

// ----- rtl/snr_crossing_steer_trigger.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snr_crossing_steer_trigger
// SNR threshold crossing detector that arms and runs station steering periods.
// ----------------------------------------------------------------------------
// Every event item yields exactly one result item. The item is evaluated in
// the cycle it is accepted: the state and the result register update on that
// edge, so the result is offered in the next cycle, and a new item can be
// taken every cycle unless the result output stalls. in_ready_o is high whenever
// the result register is empty or its item is being taken in the same cycle;
// the single result register is the only buffering, so throughput is one item
// per cycle while the output takes results. Configuration writes take effect
// on the next edge and should be made while no item is in flight.
module snr_crossing_steer_trigger (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sxst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sxst_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    mode_i,
  input  logic [sxst_pkg::SnrW-1:0]     snr_db_i,
  input  logic [sxst_pkg::TrafficW-1:0] traffic_bytes_i,
  input  logic                          has_beacon_report_i,
  input  logic                          has_bss_transition_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          enforce_start_o,
  output logic                          enforce_end_o,
  output logic                          enforce_active_o,
  output logic [1:0]                    crossing_o,
  output logic                          pending_o,
  output logic                          traffic_idle_o
);
  import sxst_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  logic    in_accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  sxst_core u_core (
    .cfg_i                (cfg_q),
    .state_i              (state_q),
    .mode_i               (mode_i),
    .snr_db_i             (snr_db_i),
    .traffic_bytes_i      (traffic_bytes_i),
    .has_beacon_report_i  (has_beacon_report_i),
    .has_bss_transition_i (has_bss_transition_i),
    .state_o              (state_d),
    .result_o             (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enforce_ticks: EnforceTicksReset, default: '0};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SNR_THRESHOLD:  cfg_q.snr_threshold     <= cfg_wdata_i[SnrW-1:0];
        REG_WATERMARK_MODE: cfg_q.watermark_mode    <= cfg_wdata_i[1:0];
        REG_IDLE_LIMIT_EN:  cfg_q.idle_limit_enable <= cfg_wdata_i[0];
        REG_IDLE_BYTES_LIM: cfg_q.idle_bytes_limit  <= cfg_wdata_i[TrafficW-1:0];
        REG_ENFORCE_TICKS:  cfg_q.enforce_ticks     <= cfg_wdata_i[TicksW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign enforce_start_o  = res_q.enforce_start;
  assign enforce_end_o    = res_q.enforce_end;
  assign enforce_active_o = res_q.enforce_active;
  assign crossing_o       = res_q.crossing;
  assign pending_o        = res_q.pending;
  assign traffic_idle_o   = res_q.traffic_idle;

  a_start_loads_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_d.enforce_start) |=> (state_q.ticks_left != '0))
    else $error("enforcement start did not load a period");

  a_period_needs_station: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.ticks_left != '0) |-> (state_q.station_present && !state_q.pending_flag))
    else $error("period running without station or with pending flag");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.snr_fill != 2'd3))
    else $error("sample fill count out of range");

  a_start_end_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.enforce_start && res_q.enforce_end))
    else $error("start and end reported on one item");

  a_state_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(state_q))
    else $error("state changed without an accepted item");

endmodule
`default_nettype wire

// ----- bench/sxst_result_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sxst_result_check
// Watches the event, result and register ports of the steer trigger, keeps
// its own copy of the trigger state, predicts one result per event item and
// compares every result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sxst_result_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sxst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sxst_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [2:0]                    mode_i,
  input  logic [sxst_pkg::SnrW-1:0]     snr_db_i,
  input  logic [sxst_pkg::TrafficW-1:0] traffic_bytes_i,
  input  logic                          has_beacon_report_i,
  input  logic                          has_bss_transition_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          enforce_start_i,
  input  logic                          enforce_end_i,
  input  logic                          enforce_active_i,
  input  logic [1:0]                    crossing_i,
  input  logic                          pending_i,
  input  logic                          traffic_idle_i,
  output int                            mismatch_count_o,
  output int                            open_results_o
);
  import sxst_pkg::*;

  cfg_t    trig_cfg;
  state_t  trig_st;
  result_t steer_results_q[$];

  task automatic report_mismatch(input string what, input logic [1:0] want,
                                 input logic [1:0] got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count_o++;
  endtask

  function automatic crossing_e held_crossing();
    logic old_hi;
    logic new_hi;
    old_hi = trig_st.older_snr >= trig_cfg.snr_threshold;
    new_hi = trig_st.newer_snr >= trig_cfg.snr_threshold;
    if (trig_st.snr_fill != 2'd2) return CROSS_NONE;
    if (!old_hi && new_hi) return CROSS_UP;
    if (old_hi && !new_hi) return CROSS_DOWN;
    return CROSS_NONE;
  endfunction

  function automatic logic station_idle();
    if (trig_cfg.watermark_mode == WM_BOTTOM_LOW) return 1'b1;
    if (!trig_cfg.idle_limit_enable) return 1'b1;
    if (!trig_st.traffic_seen) return 1'b0;
    return trig_st.last_traffic < trig_cfg.idle_bytes_limit;
  endfunction

  // Update pending and idle after a sample or traffic report; start a period when armed.
  function automatic logic start_if_armed();
    logic      caps_ok;
    crossing_e x;
    if (!trig_st.station_present || trig_st.ticks_left != '0) return 1'b0;
    case (trig_cfg.watermark_mode)
      WM_HIGH, WM_LOW: caps_ok = 1'b1;
      WM_BOTTOM_LOW:   caps_ok = !trig_st.cap_beacon && !trig_st.cap_transition;
      default:         caps_ok = 1'b0;
    endcase
    if (!caps_ok) return 1'b0;
    x = held_crossing();
    if (x == CROSS_UP) begin
      trig_st.pending_flag = (trig_cfg.watermark_mode == WM_HIGH);
    end else if (x == CROSS_DOWN) begin
      trig_st.pending_flag = (trig_cfg.watermark_mode != WM_HIGH);
    end
    trig_st.idle_flag = station_idle();
    if (trig_cfg.watermark_mode != WM_BOTTOM_LOW && !trig_st.idle_flag) return 1'b0;
    if (!trig_st.pending_flag) return 1'b0;
    trig_st.pending_flag = 1'b0;
    trig_st.ticks_left = (trig_cfg.enforce_ticks != '0) ? trig_cfg.enforce_ticks : 16'd1;
    return 1'b1;
  endfunction

  task automatic step_event(input logic [2:0] ev, input logic [SnrW-1:0] snr,
                            input logic [TrafficW-1:0] bytes, input logic beacon,
                            input logic bss, output result_t r);
    logic started;
    logic ended;
    logic present;
    started = 1'b0;
    ended   = 1'b0;
    case (ev)
      EV_SNR: begin
        trig_st.older_snr = trig_st.newer_snr;
        trig_st.newer_snr = snr;
        if (trig_st.snr_fill != 2'd2) trig_st.snr_fill = trig_st.snr_fill + 2'd1;
        started = start_if_armed();
      end
      EV_TRAFFIC: begin
        trig_st.last_traffic = bytes;
        trig_st.traffic_seen = 1'b1;
        started = start_if_armed();
      end
      EV_CONNECT: begin
        trig_st.station_present = 1'b1;
        if (beacon) trig_st.cap_beacon = 1'b1;
        if (bss) trig_st.cap_transition = 1'b1;
      end
      EV_DISCONNECT: begin
        ended   = trig_st.ticks_left != '0;
        trig_st = '0;
      end
      EV_TICK: begin
        if (trig_st.ticks_left != '0) begin
          trig_st.ticks_left = trig_st.ticks_left - 16'd1;
          if (trig_st.ticks_left == '0) begin
            // expiry drops the history but keeps the station
            present = trig_st.station_present;
            trig_st = '0;
            trig_st.station_present = present;
            ended = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.enforce_start  = started;
    r.enforce_end    = ended;
    r.enforce_active = trig_st.ticks_left != '0;
    r.crossing       = held_crossing();
    r.pending        = trig_st.pending_flag;
    r.traffic_idle   = trig_st.idle_flag;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      trig_cfg = '0;
      trig_cfg.enforce_ticks = EnforceTicksReset;
      trig_st = '0;
      steer_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SNR_THRESHOLD:  trig_cfg.snr_threshold     = cfg_wdata_i[SnrW-1:0];
          REG_WATERMARK_MODE: trig_cfg.watermark_mode    = cfg_wdata_i[1:0];
          REG_IDLE_LIMIT_EN:  trig_cfg.idle_limit_enable = cfg_wdata_i[0];
          REG_IDLE_BYTES_LIM: trig_cfg.idle_bytes_limit  = cfg_wdata_i[TrafficW-1:0];
          REG_ENFORCE_TICKS:  trig_cfg.enforce_ticks     = cfg_wdata_i[TicksW-1:0];
          default: ;
        endcase
      end
      // the result taken on this edge belongs to an earlier item
      if (out_valid_i && out_ready_i) begin
        if (steer_results_q.size() == 0) begin
          report_mismatch("result without an outstanding item", 2'd0, 2'd1);
        end else begin
          want = steer_results_q.pop_front();
          if (enforce_start_i !== want.enforce_start)
            report_mismatch("enforce_start", 2'(want.enforce_start), 2'(enforce_start_i));
          if (enforce_end_i !== want.enforce_end)
            report_mismatch("enforce_end", 2'(want.enforce_end), 2'(enforce_end_i));
          if (enforce_active_i !== want.enforce_active)
            report_mismatch("enforce_active", 2'(want.enforce_active),
                            2'(enforce_active_i));
          if (crossing_i !== want.crossing)
            report_mismatch("crossing", want.crossing, crossing_i);
          if (pending_i !== want.pending)
            report_mismatch("pending", 2'(want.pending), 2'(pending_i));
          if (traffic_idle_i !== want.traffic_idle)
            report_mismatch("traffic_idle", 2'(want.traffic_idle), 2'(traffic_idle_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_event(mode_i, snr_db_i, traffic_bytes_i, has_beacon_report_i,
                   has_bss_transition_i, want);
        steer_results_q.push_back(want);
      end
    end
    open_results_o = steer_results_q.size();
  end

endmodule

// ----- bench/snr_crossing_steer_trigger_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// snr_crossing_steer_trigger_test
// Drives event items into the steer trigger through a directed opening and
// randomised phases under several register settings, with random stalls on
// both channels in all but the last phase; the result checker beside the block gives the verdict.
// ----------------------------------------------------------------------------
module snr_crossing_steer_trigger_test;
  import sxst_pkg::*;

  localparam logic [1:0] WmUnused      = 2'd3;
  localparam logic [2:0] EvUnusedFirst = 3'd5;
  localparam logic [2:0] EvUnusedLast  = 3'd7;
  localparam logic [TrafficW-1:0] BytesMax = 48'hFFFF_FFFF_FFFF;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [2:0]          mode;
  logic [SnrW-1:0]     snr_db;
  logic [TrafficW-1:0] traffic_bytes;
  logic                has_beacon;
  logic                has_bss;
  logic                out_valid;
  logic                out_ready;
  logic                enforce_start;
  logic                enforce_end;
  logic                enforce_active;
  logic [1:0]          crossing;
  logic                pending;
  logic                traffic_idle;
  int                  mismatch_count;
  int                  open_results;

  bit                  src_stalls  = 1'b1;
  bit                  sink_stalls = 1'b1;
  bit                  hold_sink   = 1'b0;
  logic [SnrW-1:0]     cur_thr;
  logic [TrafficW-1:0] cur_lim;

  snr_crossing_steer_trigger dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .mode_i              (mode),
    .snr_db_i            (snr_db),
    .traffic_bytes_i     (traffic_bytes),
    .has_beacon_report_i (has_beacon),
    .has_bss_transition_i(has_bss),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .enforce_start_o     (enforce_start),
    .enforce_end_o       (enforce_end),
    .enforce_active_o    (enforce_active),
    .crossing_o          (crossing),
    .pending_o           (pending),
    .traffic_idle_o      (traffic_idle)
  );

  sxst_result_check u_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .mode_i              (mode),
    .snr_db_i            (snr_db),
    .traffic_bytes_i     (traffic_bytes),
    .has_beacon_report_i (has_beacon),
    .has_bss_transition_i(has_bss),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .enforce_start_i     (enforce_start),
    .enforce_end_i       (enforce_end),
    .enforce_active_i    (enforce_active),
    .crossing_i          (crossing),
    .pending_i           (pending),
    .traffic_idle_i      (traffic_idle),
    .mismatch_count_o    (mismatch_count),
    .open_results_o      (open_results)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [TrafficW-1:0] rand_bytes();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[TrafficW-1:0];
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_event(input logic [2:0] ev, input logic [SnrW-1:0] snr,
                            input logic [TrafficW-1:0] bytes, input logic beacon,
                            input logic bss);
    if (src_stalls && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= ev;
    snr_db        <= snr;
    traffic_bytes <= bytes;
    has_beacon    <= beacon;
    has_bss       <= bss;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (open_results != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [SnrW-1:0] thr, input logic [1:0] wm,
                            input logic ien, input logic [TrafficW-1:0] lim,
                            input logic [TicksW-1:0] ticks);
    drain();
    write_reg(REG_SNR_THRESHOLD, CfgDataW'(thr));
    write_reg(REG_WATERMARK_MODE, CfgDataW'(wm));
    write_reg(REG_IDLE_LIMIT_EN, CfgDataW'(ien));
    write_reg(REG_IDLE_BYTES_LIM, CfgDataW'(lim));
    write_reg(REG_ENFORCE_TICKS, CfgDataW'(ticks));
    cur_thr = thr;
    cur_lim = lim;
  endtask

  // Mostly SNR samples and traffic reports, many near the threshold and limit, with enough ticks to let
  // periods run out and the odd connect, disconnect or unused event.
  task automatic random_event();
    int                  pick;
    logic [2:0]          ev;
    logic [SnrW-1:0]     snr;
    logic [TrafficW-1:0] bytes;
    logic                beacon;
    logic                bss;
    pick   = $urandom_range(0, 99);
    snr    = SnrW'($urandom);
    bytes  = rand_bytes();
    beacon = ($urandom_range(0, 7) == 0);
    bss    = ($urandom_range(0, 7) == 0);
    if (pick < 40) begin
      ev = EV_SNR;
      if (pick >= 10) snr = cur_thr + SnrW'($urandom_range(0, 8)) - 8'd4;
    end else if (pick < 58) begin
      ev = EV_TRAFFIC;
      if (pick >= 44) bytes = cur_lim + TrafficW'($urandom_range(0, 4)) - 48'd2;
    end else if (pick < 64) begin
      ev = EV_CONNECT;
    end else if (pick < 68) begin
      ev = EV_DISCONNECT;
    end else if (pick < 96) begin
      ev = EV_TICK;
    end else begin
      ev = 3'($urandom_range(EvUnusedFirst, EvUnusedLast));
    end
    send_event(ev, snr, bytes, beacon, bss);
  endtask

  initial begin : sink
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        // hold off long enough for the block to back up its input
        out_ready <= 1'b0;
        repeat (48) @(negedge clk);
        hold_sink = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : source
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    mode          = EV_TICK;
    snr_db        = '0;
    traffic_bytes = '0;
    has_beacon    = 1'b0;
    has_bss       = 1'b0;
    cur_thr       = '0;
    cur_lim       = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero period length, high watermark, traffic check off
    set_config(8'd100, WM_HIGH, 1'b0, '0, 16'd0);
    send_event(EV_SNR, 8'd255, '0, 1'b1, 1'b1);
    send_event(EV_TRAFFIC, '0, BytesMax, 1'b0, 1'b0);
    send_event(EV_TICK, '0, '0, 1'b0, 1'b0);
    send_event(EvUnusedFirst, 8'd255, BytesMax, 1'b1, 1'b1);
    send_event(EvUnusedLast, 8'd0, '0, 1'b0, 1'b0);
    send_event(EV_CONNECT, '0, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd0, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd100, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd0, '0, 1'b0, 1'b0);
    send_event(EV_TICK, '0, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd200, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd99, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd100, '0, 1'b0, 1'b0);
    send_event(EV_DISCONNECT, '0, '0, 1'b0, 1'b0);
    send_event(EV_DISCONNECT, '0, '0, 1'b0, 1'b0);

    // bottom-low: capabilities block the start, then a bare station passes
    set_config(8'd50, WM_BOTTOM_LOW, 1'b1, 48'd1000, 16'hFFFF);
    send_event(EV_CONNECT, '0, '0, 1'b1, 1'b0);
    send_event(EV_SNR, 8'd60, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd10, '0, 1'b0, 1'b0);
    send_event(EV_DISCONNECT, '0, '0, 1'b0, 1'b0);
    send_event(EV_CONNECT, '0, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd60, '0, 1'b0, 1'b0);
    send_event(EV_SNR, 8'd10, '0, 1'b0, 1'b0);
    send_event(EV_TICK, '0, '0, 1'b0, 1'b0);
    send_event(EV_DISCONNECT, '0, '0, 1'b0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(8'd0, WM_HIGH, 1'b0, '0, 16'd1);
        1: set_config(8'd255, WM_LOW, 1'b1, BytesMax, 16'hFFFF);
        2: set_config(SnrW'($urandom), WM_BOTTOM_LOW, 1'($urandom), rand_bytes(), 16'd3);
        3: set_config(SnrW'($urandom), WM_HIGH, 1'b1, TrafficW'($urandom_range(1, 4096)),
                      TicksW'($urandom_range(1, 6)));
        4: set_config(SnrW'($urandom), WM_LOW, 1'b1, rand_bytes(),
                      TicksW'($urandom_range(1, 6)));
        5: set_config(SnrW'($urandom), WmUnused, 1'($urandom), rand_bytes(), 16'd2);
        default: set_config(SnrW'($urandom), 2'($urandom_range(WM_HIGH, WM_BOTTOM_LOW)),
                            1'($urandom), rand_bytes(), TicksW'($urandom_range(1, 8)));
      endcase
      if (ph == 3) hold_sink = 1'b1;
      if (ph == 7) begin
        src_stalls  = 1'b0;
        sink_stalls = 1'b0;
      end
      repeat (60) random_event();
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- snr_crossing_steer_trigger.f -----
rtl/sxst_pkg.sv
rtl/sxst_core.sv
rtl/snr_crossing_steer_trigger.sv
bench/sxst_result_check.sv
bench/snr_crossing_steer_trigger_test.sv
